@@ rtl/assert_macros.svh @@
// Assertion macros for the expander RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NOW(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NOW(label, clk, rst_n, expr)
`endif
`endif

@@ rtl/nfwlz_pkg.sv @@
// Shared codes and constants for the near/far word LZ expander.
package nfwlz_pkg;
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_END  = 2'd1;
    localparam logic [1:0] ERR_REF  = 2'd2;
    localparam logic [0:0] REG_NEAR_TAG = 1'b0;
    localparam logic [0:0] REG_FAR_TAG  = 1'b1;
    localparam int NUM_WORDS = 4;
endpackage

@@ rtl/nfwlz_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module nfwlz_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/near_far_word_lz_expander_top.sv @@
// Top level of the near/far word LZ expander.
// Usage: compressed bytes enter on in_valid/in_stall with in_byte and first
// (first restarts the parser at a header). Expanded words leave on
// out_valid/out_stall as beats of up to four words with word_count, last,
// done_res and error. Tags are set through cfg_we/cfg_index/cfg_data while idle.
// Header, count and tag bytes that make no beat leave the input free. A byte
// that makes a single beat (literal, escape, zero header, error) loads the
// output register and input stalls until that beat is taken.
// A copy of count words reads history word by word through the registered
// RAM read port: each word takes a read state (S_RD) and then a write state
// (S_WR), since the next source may be the word just written. Input is stalled
// meanwhile; a beat is pushed each CHUNK words (at most four) or at the end.
// Reset clears the parser, sets tags to 167/168; history needs no clearing.
// When the receiver stalls, the finished beat holds in the output register;
// a copy waits at its next beat; input is accepted only when the output is free.
module near_far_word_lz_expander_top #(
    parameter int HISTORY_WORDS = 4096,
    parameter int WORDS_PER_RESULT = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        first,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] word0,
    output logic [15:0] word1,
    output logic [15:0] word2,
    output logic [15:0] word3,
    output logic [2:0]  word_count,
    output logic        last,
    output logic        done_res,
    output logic [1:0]  error,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import nfwlz_pkg::*;
`include "assert_macros.svh"

    localparam int AW = $clog2(HISTORY_WORDS);
    localparam int CHUNK = (WORDS_PER_RESULT < NUM_WORDS) ? WORDS_PER_RESULT : NUM_WORDS;

    typedef enum logic [3:0] {
        S_HDR_LO, S_HDR_HI, S_COUNT, S_TAG, S_ESC, S_NEAR, S_FAR_LO, S_FAR_HI,
        S_RD, S_WR
    } state_t;

    state_t       state_reg;
    logic [7:0]   near_tag_reg, far_tag_reg;
    logic [15:0]  expanded_reg;
    logic [16:0]  written_reg;
    logic [7:0]   count_reg;
    logic [7:0]   low_reg;
    logic         stopped_reg;
    logic [15:0]  src_reg;
    logic [7:0]   left_reg;
    logic [1:0]   k_reg;
    logic [15:0]  buf_reg [NUM_WORDS];
    logic         ov_reg;
    logic [15:0]  ow_reg [NUM_WORDS];
    logic [2:0]   oc_reg;
    logic         ol_reg, od_reg;
    logic [1:0]   oe_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_wdata, ram_rdata;

    nfwlz_ram #(.WIDTH(16), .DEPTH(HISTORY_WORDS)) u_hist (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    logic busy;
    assign busy = (state_reg == S_RD) || (state_reg == S_WR);
    assign in_stall = busy || ov_reg;
    assign out_valid = ov_reg;
    assign word0 = ow_reg[0];
    assign word1 = ow_reg[1];
    assign word2 = ow_reg[2];
    assign word3 = ow_reg[3];
    assign word_count = oc_reg;
    assign last = ol_reg;
    assign done_res = od_reg;
    assign error = oe_reg;

    logic acc;
    assign acc = in_valid && !in_stall;

    // copy word waits while the output register is full and this word completes a beat
    logic wr_block;
    assign wr_block = ov_reg && (k_reg == 2'(CHUNK - 1) || left_reg == 8'd1);

    // copy setup values
    logic [16:0] wpos;
    logic [15:0] src_c;
    logic        src_neg;
    logic [17:0] end_sum;
    logic        lit;
    logic [15:0] lit_w;
    logic [16:0] wr_after;
    always_comb
    begin
        wpos = {1'b0, written_reg[16:1]};
        if (state_reg == S_NEAR)
        begin
            src_neg = wpos < {9'd0, in_byte};
            src_c = 16'(wpos - {9'd0, in_byte});
        end
        else
        begin
            src_neg = 1'b0;
            src_c = {in_byte, low_reg};
        end
        end_sum = {1'b0, written_reg} + {9'd0, count_reg, 1'b0};
        lit = 1'b0;
        lit_w = {in_byte, count_reg};
        if (state_reg == S_TAG && !(count_reg == 8'd0 &&
            (in_byte == near_tag_reg || in_byte == far_tag_reg)) &&
            in_byte != near_tag_reg && in_byte != far_tag_reg)
        begin
            lit = 1'b1;
        end
        if (state_reg == S_ESC)
        begin
            lit = 1'b1;
            lit_w = {low_reg, in_byte};
        end
        wr_after = written_reg + 17'd2;
        ram_we = 1'b0;
        ram_waddr = written_reg[AW:1];
        ram_wdata = lit_w;
        ram_raddr = src_reg[AW-1:0];
        if (acc && !first && !stopped_reg && lit)
        begin
            ram_we = 1'b1;
        end
        if (state_reg == S_WR && !wr_block)
        begin
            ram_we = 1'b1;
            ram_wdata = ram_rdata;
        end
    end

    logic [16:0] lo_bound;
    assign lo_bound = wpos - 17'(HISTORY_WORDS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HDR_LO;
            near_tag_reg <= 8'd167;
            far_tag_reg <= 8'd168;
            expanded_reg <= '0;
            written_reg <= '0;
            count_reg <= '0;
            low_reg <= '0;
            stopped_reg <= 1'b0;
            src_reg <= '0;
            left_reg <= '0;
            ov_reg <= 1'b0;
            k_reg <= '0;
            oc_reg <= '0;
            ol_reg <= 1'b0;
            od_reg <= 1'b0;
            oe_reg <= ERR_NONE;
            for (int j = 0; j < NUM_WORDS; j++)
            begin
                buf_reg[j] <= '0;
                ow_reg[j] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_NEAR_TAG) near_tag_reg <= cfg_data;
                else far_tag_reg <= cfg_data;
            end
            if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
            if (acc && (first || !stopped_reg))
            begin
                automatic state_t st = first ? S_HDR_LO : state_reg;
                oc_reg <= '0;
                ol_reg <= 1'b1;
                oe_reg <= ERR_NONE;
                od_reg <= 1'b0;
                for (int j = 0; j < NUM_WORDS; j++) ow_reg[j] <= '0;
                if (first)
                begin
                    written_reg <= '0;
                    count_reg <= '0;
                    stopped_reg <= 1'b0;
                end
                case (st)
                    S_HDR_LO:
                    begin
                        low_reg <= in_byte;
                        state_reg <= S_HDR_HI;
                    end
                    S_HDR_HI:
                    begin
                        expanded_reg <= {in_byte, low_reg};
                        written_reg <= '0;
                        state_reg <= S_COUNT;
                        if ({in_byte, low_reg} == 16'd0)
                        begin
                            ov_reg <= 1'b1;
                            od_reg <= 1'b1;
                            stopped_reg <= 1'b1;
                            state_reg <= S_HDR_LO;
                        end
                    end
                    S_COUNT:
                    begin
                        count_reg <= in_byte;
                        state_reg <= S_TAG;
                    end
                    S_TAG, S_ESC:
                    begin
                        if (lit)
                        begin
                            written_reg <= wr_after;
                            ov_reg <= 1'b1;
                            oc_reg <= 3'd1;
                            ow_reg[0] <= lit_w;
                            state_reg <= S_COUNT;
                            if (wr_after >= {1'b0, expanded_reg})
                            begin
                                od_reg <= 1'b1;
                                stopped_reg <= 1'b1;
                                state_reg <= S_HDR_LO;
                            end
                        end
                        else if (count_reg == 8'd0 && (in_byte == near_tag_reg ||
                                 in_byte == far_tag_reg))
                        begin
                            low_reg <= in_byte;
                            state_reg <= S_ESC;
                        end
                        else if (in_byte == near_tag_reg) state_reg <= S_NEAR;
                        else state_reg <= S_FAR_LO;
                    end
                    S_FAR_LO:
                    begin
                        low_reg <= in_byte;
                        state_reg <= S_FAR_HI;
                    end
                    S_NEAR, S_FAR_HI:
                    begin
                        state_reg <= S_COUNT;
                        if (end_sum > {2'b0, expanded_reg})
                        begin
                            ov_reg <= 1'b1;
                            oe_reg <= ERR_END;
                            stopped_reg <= 1'b1;
                            state_reg <= S_HDR_LO;
                        end
                        else if (count_reg != 8'd0)
                        begin
                            if (src_neg || {1'b0, src_c} >= wpos ||
                                (wpos > 17'(HISTORY_WORDS) && {1'b0, src_c} < lo_bound))
                            begin
                                ov_reg <= 1'b1;
                                oe_reg <= ERR_REF;
                                stopped_reg <= 1'b1;
                                state_reg <= S_HDR_LO;
                            end
                            else
                            begin
                                src_reg <= src_c;
                                left_reg <= count_reg;
                                k_reg <= '0;
                                state_reg <= S_RD;
                            end
                        end
                    end
                    default: state_reg <= S_HDR_LO;
                endcase
            end
            else if (state_reg == S_RD)
            begin
                state_reg <= S_WR;
            end
            else if (state_reg == S_WR && !wr_block)
            begin
                buf_reg[k_reg] <= ram_rdata;
                written_reg <= wr_after;
                src_reg <= src_reg + 16'd1;
                left_reg <= left_reg - 8'd1;
                if (k_reg == 2'(CHUNK - 1) || left_reg == 8'd1)
                begin
                    ov_reg <= 1'b1;
                    oc_reg <= {1'b0, k_reg} + 3'd1;
                    for (int j = 0; j < NUM_WORDS; j++)
                    begin
                        if (2'(j) < k_reg) ow_reg[j] <= buf_reg[j];
                        else if (2'(j) == k_reg) ow_reg[j] <= ram_rdata;
                        else ow_reg[j] <= '0;
                    end
                    ol_reg <= (left_reg == 8'd1);
                    oe_reg <= ERR_NONE;
                    od_reg <= (left_reg == 8'd1) && (wr_after >= {1'b0, expanded_reg});
                    k_reg <= '0;
                end
                else
                begin
                    k_reg <= k_reg + 2'd1;
                end
                if (left_reg == 8'd1)
                begin
                    state_reg <= S_COUNT;
                    if (wr_after >= {1'b0, expanded_reg})
                    begin
                        stopped_reg <= 1'b1;
                        state_reg <= S_HDR_LO;
                    end
                end
                else
                begin
                    state_reg <= S_RD;
                end
            end
        end
    end

    `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, busy |-> !acc)
    `ASSERT_IMPL(a_out_hold, clk, rst_n, (ov_reg && out_stall) |=> ov_reg)
    `ASSERT_NOW(a_count_range, clk, rst_n, !ov_reg || oc_reg <= 3'(CHUNK))
    `ASSERT_IMPL(a_rd_then_wr, clk, rst_n, (state_reg == S_RD) |=> (state_reg == S_WR))
endmodule

@@ tb/tb_near_far_word_lz_expander_top.sv @@
// Self-checking testbench for the near/far word LZ expander: directed table, then random streams.
module tb_near_far_word_lz_expander_top;
    timeunit 1ns;
    timeprecision 1ps;
    import nfwlz_pkg::*;

    localparam int HIST = 4096;

    typedef enum int {P_HDR_LO, P_HDR_HI, P_COUNT, P_TAG, P_ESC, P_NEAR, P_FAR_LO, P_FAR_HI} phase_e;

    typedef struct {
        logic [15:0] w [4];
        logic [2:0]  cnt;
        logic        lst;
        logic        dn;
        logic [1:0]  err;
    } beat_t;

    typedef struct {
        logic [7:0] b;
        logic       f;
        bit         typed;
        logic [2:0] cnt;
        logic       dn;
        logic [1:0] err;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = '0;
    logic        first = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] word0, word1, word2, word3;
    logic [2:0]  word_count;
    logic        last, done_res;
    logic [1:0]  error;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    near_far_word_lz_expander_top DUT (.*);

    // expander model state
    logic [15:0] hist_mem [HIST];
    phase_e      phase;
    int          len_bytes, wr_bytes, hold_cnt, hold_lo;
    bit          halted;
    logic [7:0]  tag_near = 8'd167, tag_far = 8'd168;

    beat_t expected_beats [$];
    beat_t step_beats [$];
    int    fails = 0, n_items = 0, n_beats = 0, n_blocks = 0, n_errs = 0;
    bit    calm = 1'b0;

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report(input string what, input int got, input int want);
        if (fails < 30)
            $display("mismatch %s: got %0h want %0h (beat %0d)", what, got, want, n_beats);
        fails++;
    endtask

    function automatic void emit_beat(input logic [15:0] w [4], input int cnt, input int err);
        beat_t r;
        for (int j = 0; j < 4; j++)
            r.w[j] = (j < cnt) ? w[j] : 16'h0;
        r.cnt = cnt[2:0];
        r.lst = 1'b0;
        r.dn  = (err == 0 && wr_bytes >= len_bytes);
        r.err = err[1:0];
        step_beats.push_back(r);
    endfunction

    function automatic void put_word(input logic [15:0] w);
        hist_mem[(wr_bytes >> 1) % HIST] = w;
        wr_bytes = (wr_bytes + 2) & 32'h1FFFF;
    endfunction

    function automatic void check_end();
        if (wr_bytes >= len_bytes) begin
            halted = 1'b1;
            phase = P_HDR_LO;
        end
    endfunction

    function automatic void stop_err(input int err);
        logic [15:0] z [4];
        z = '{default: 16'h0};
        emit_beat(z, 0, err);
        halted = 1'b1;
        phase = P_HDR_LO;
    endfunction

    function automatic void lit_word(input logic [15:0] w);
        logic [15:0] t [4];
        t = '{default: 16'h0};
        t[0] = w;
        put_word(w);
        emit_beat(t, 1, ERR_NONE);
        check_end();
    endfunction

    function automatic void copy_words(input int src, input int cnt);
        int wpos;
        int k;
        logic [15:0] buf4 [4];
        logic [15:0] w;
        wpos = wr_bytes >> 1;
        k = 0;
        buf4 = '{default: 16'h0};
        if (wr_bytes + 2 * cnt > len_bytes) begin
            stop_err(ERR_END);
            return;
        end
        if (cnt == 0)
            return;
        if (src < 0 || src >= wpos || src < wpos - HIST) begin
            stop_err(ERR_REF);
            return;
        end
        for (int i = 0; i < cnt; i++) begin
            w = hist_mem[(src + i) % HIST];
            put_word(w);
            buf4[k] = w;
            k++;
            if (k == 4 || i + 1 == cnt) begin
                emit_beat(buf4, k, ERR_NONE);
                k = 0;
            end
        end
        phase = P_COUNT;
        check_end();
    endfunction

    // expected beats of one accepted byte go to step_beats
    function automatic void expand_byte(input logic [7:0] b, input logic f);
        logic [15:0] z [4];
        beat_t r;
        step_beats.delete();
        z = '{default: 16'h0};
        if (f) begin
            phase = P_HDR_LO;
            wr_bytes = 0;
            hold_cnt = 0;
            hold_lo = 0;
            halted = 1'b0;
        end else if (halted) begin
            return;
        end
        case (phase)
            P_HDR_LO: begin
                hold_lo = b;
                phase = P_HDR_HI;
            end
            P_HDR_HI: begin
                len_bytes = hold_lo | (int'(b) << 8);
                wr_bytes = 0;
                phase = P_COUNT;
                if (len_bytes == 0) begin
                    emit_beat(z, 0, ERR_NONE);
                    halted = 1'b1;
                    phase = P_HDR_LO;
                end
            end
            P_COUNT: begin
                hold_cnt = b;
                phase = P_TAG;
            end
            P_TAG: begin
                if (hold_cnt == 0 && (b == tag_near || b == tag_far)) begin
                    hold_lo = b;
                    phase = P_ESC;
                end else if (b == tag_near) begin
                    phase = P_NEAR;
                end else if (b == tag_far) begin
                    phase = P_FAR_LO;
                end else begin
                    phase = P_COUNT;
                    lit_word({b, hold_cnt[7:0]});
                end
            end
            P_ESC: begin
                phase = P_COUNT;
                lit_word({hold_lo[7:0], b});
            end
            P_NEAR: begin
                phase = P_COUNT;
                copy_words((wr_bytes >> 1) - int'(b), hold_cnt);
            end
            P_FAR_LO: begin
                hold_lo = b;
                phase = P_FAR_HI;
            end
            default: begin
                phase = P_COUNT;
                copy_words(hold_lo | (int'(b) << 8), hold_cnt);
            end
        endcase
        if (step_beats.size() > 0) begin
            r = step_beats[$];
            r.lst = 1'b1;
            step_beats[$] = r;
        end
    endfunction

    // drive one beat on the input; model runs at acceptance
    task automatic send(input logic [7:0] b, input logic f);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        first    <= f;
        do
            @(posedge clk);
        while (in_stall);
        expand_byte(b, f);
        foreach (step_beats[i])
            expected_beats.push_back(step_beats[i]);
        if (step_beats.size() > 0 && step_beats[$].err != ERR_NONE)
            n_errs++;
        n_items++;
        @(negedge clk);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        drop_valid();
        while (expected_beats.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_tag(input logic [0:0] idx, input logic [7:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        if (idx == REG_NEAR_TAG)
            tag_near = v;
        else
            tag_far = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] plain_hi();
        logic [7:0] v;
        do
            v = 8'($urandom_range(0, 255));
        while (v == tag_near || v == tag_far);
        return v;
    endfunction

    // one random compressed block, mostly well formed
    task automatic rand_block();
        int L, wpos, c, kind, src, left;
        if ($urandom_range(0, 19) == 0)
            L = 0;
        else if ($urandom_range(0, 15) == 0)
            L = $urandom_range(200, 700);
        else
            L = $urandom_range(1, 70);
        n_blocks++;
        send(L[7:0], 1'b1);
        send(L[15:8], 1'b0);
        while (!halted && n_items < 290) begin
            wpos = wr_bytes >> 1;
            left = (len_bytes - wr_bytes) / 2;
            kind = $urandom_range(0, 99);
            if ($urandom_range(0, 60) == 0)
                return;
            if (kind < 35 || wpos == 0 && kind < 70) begin
                send(8'($urandom_range(0, 255)), 1'b0);
                send(plain_hi(), 1'b0);
            end else if (kind < 50) begin
                send(8'd0, 1'b0);
                send($urandom_range(0, 1) ? tag_near : tag_far, 1'b0);
                send(8'($urandom_range(0, 255)), 1'b0);
            end else if (kind < 70) begin
                c = $urandom_range(0, 9) == 0 ? $urandom_range(0, 255)
                                              : $urandom_range(0, left < 12 ? left : 12);
                src = $urandom_range(0, 12) == 0 ? $urandom_range(0, 255)
                                                 : $urandom_range(1, wpos < 255 ? wpos : 255);
                if (c == 0 && tag_near == tag_far)
                    c = 1;
                send(c[7:0], 1'b0);
                send(tag_near, 1'b0);
                send(src[7:0], 1'b0);
            end else if (kind < 90 && tag_near != tag_far) begin
                c = $urandom_range(0, 9) == 0 ? $urandom_range(0, 255)
                                              : $urandom_range(1, left < 12 ? left : 12);
                src = $urandom_range(0, 12) == 0 ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, wpos - 1);
                send(c[7:0], 1'b0);
                send(tag_far, 1'b0);
                send(src[7:0], 1'b0);
                send(src[15:8], 1'b0);
            end else begin
                send(8'($urandom_range(0, 255)), 1'b0);
            end
        end
        if ($urandom_range(0, 3) == 0)
            send(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // receiver stall bursts
    initial begin
        forever begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        beat_t e;
        if (rst_n && out_valid && !out_stall) begin
            n_beats++;
            if (expected_beats.size() == 0) begin
                report("unexpected beat", word_count, 0);
            end else begin
                e = expected_beats.pop_front();
                if (word0 !== e.w[0]) report("word0", word0, e.w[0]);
                if (word1 !== e.w[1]) report("word1", word1, e.w[1]);
                if (word2 !== e.w[2]) report("word2", word2, e.w[2]);
                if (word3 !== e.w[3]) report("word3", word3, e.w[3]);
                if (word_count !== e.cnt) report("word_count", word_count, e.cnt);
                if (last !== e.lst) report("last", last, e.lst);
                if (done_res !== e.dn) report("done_res", done_res, e.dn);
                if (error !== e.err) report("error", error, e.err);
            end
        end
    end

    row_t rows [] = '{
        '{8'h00, 1'b1, 0, 0, 0, ERR_NONE},
        '{8'h00, 1'b0, 1, 0, 1, ERR_NONE},
        '{8'h08, 1'b1, 0, 0, 0, ERR_NONE},
        '{8'h00, 1'b0, 0, 0, 0, ERR_NONE},
        '{8'h34, 1'b0, 0, 0, 0, ERR_NONE},
        '{8'h12, 1'b0, 0, 0, 0, ERR_NONE},
        '{8'h00, 1'b0, 0, 0, 0, ERR_NONE},
        '{8'hA7, 1'b0, 0, 0, 0, ERR_NONE},
        '{8'hFF, 1'b0, 0, 0, 0, ERR_NONE},
        '{8'h02, 1'b0, 0, 0, 0, ERR_NONE},
        '{8'hA7, 1'b0, 0, 0, 0, ERR_NONE},
        '{8'h02, 1'b0, 0, 0, 0, ERR_NONE},
        '{8'h04, 1'b1, 0, 0, 0, ERR_NONE},
        '{8'h00, 1'b0, 0, 0, 0, ERR_NONE},
        '{8'h03, 1'b0, 0, 0, 0, ERR_NONE},
        '{8'hA7, 1'b0, 0, 0, 0, ERR_NONE},
        '{8'h01, 1'b0, 1, 0, 0, ERR_END},
        '{8'h55, 1'b0, 0, 0, 0, ERR_NONE},
        '{8'h06, 1'b1, 0, 0, 0, ERR_NONE},
        '{8'h00, 1'b0, 0, 0, 0, ERR_NONE},
        '{8'h01, 1'b0, 0, 0, 0, ERR_NONE},
        '{8'hA8, 1'b0, 0, 0, 0, ERR_NONE},
        '{8'h00, 1'b0, 0, 0, 0, ERR_NONE},
        '{8'h00, 1'b0, 1, 0, 0, ERR_REF},
        '{8'h01, 1'b1, 0, 0, 0, ERR_NONE}
    };

    initial begin
        beat_t t;
        phase = P_HDR_LO;
        len_bytes = 0;
        wr_bytes = 0;
        hold_cnt = 0;
        hold_lo = 0;
        halted = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table; odd length literal closes it
        foreach (rows[i]) begin
            in_valid <= 1'b1;
            in_byte  <= rows[i].b;
            first    <= rows[i].f;
            do
                @(posedge clk);
            while (in_stall);
            expand_byte(rows[i].b, rows[i].f);
            if (rows[i].typed) begin
                t.w = '{default: 16'h0};
                t.cnt = rows[i].cnt;
                t.lst = 1'b1;
                t.dn = rows[i].dn;
                t.err = rows[i].err;
                expected_beats.push_back(t);
            end else begin
                foreach (step_beats[k])
                    expected_beats.push_back(step_beats[k]);
            end
            n_items++;
            @(negedge clk);
        end
        send(8'h00, 1'b0);
        send(8'hFF, 1'b0);
        send(8'hFF, 1'b0);

        // several tag settings, extremes included; equal tags check near priority
        for (int phs = 0; phs < 6; phs++) begin
            case (phs)
                1: begin write_tag(REG_NEAR_TAG, 8'h00); write_tag(REG_FAR_TAG, 8'hFF); end
                2: begin write_tag(REG_NEAR_TAG, 8'h55); write_tag(REG_FAR_TAG, 8'h55); end
                3: begin write_tag(REG_NEAR_TAG, 8'hFF); write_tag(REG_FAR_TAG, 8'h00); end
                4: begin
                    write_tag(REG_NEAR_TAG, 8'($urandom_range(0, 255)));
                    write_tag(REG_FAR_TAG, 8'($urandom_range(0, 255)));
                end
                5: begin write_tag(REG_NEAR_TAG, 8'd167); write_tag(REG_FAR_TAG, 8'd168); end
                default: ;
            endcase
            while (n_items < 45 * (phs + 1) + 10) begin
                if (phs == 5 && n_items > 250)
                    calm = 1'b1;
                rand_block();
                if (phs == 3 && expected_beats.size() > 0)
                    wait_drained();
            end
        end
        drop_valid();
        while (expected_beats.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        $display("ran %0d input beats in %0d random blocks, %0d output beats checked",
                 n_items, n_blocks, n_beats);
        $display("tag settings: reset, extremes, equal tags, random; %0d error stops seen",
                 n_errs);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
